### rtl/uidss_pkg.sv
package uidss_pkg;

    localparam int ID_W              = 32;
    localparam int IDX_W             = 12;
    localparam int CNT_W             = 13;
    localparam int QUERY_FIELDS      = 4;
    localparam int DEF_TABLE_DEPTH   = 4096;
    localparam int DEF_IDS_PER_ENTRY = 4;

    // Query slots beyond the four carried by an item hold the padding id.
    localparam logic [ID_W-1:0] PAD_ID = {ID_W{1'b1}};

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

endpackage

### rtl/uidss_match.sv
module uidss_match #(
    parameter int IDS_PER_ENTRY = uidss_pkg::DEF_IDS_PER_ENTRY
) (
    input  logic [IDS_PER_ENTRY*uidss_pkg::ID_W-1:0] entry_row,
    input  logic [IDS_PER_ENTRY*uidss_pkg::ID_W-1:0] query_row,
    output logic                                     hit
);

    localparam int W = uidss_pkg::ID_W;

    logic [IDS_PER_ENTRY-1:0] slot_hit;

    // Each stored id must appear somewhere in the query, in any order.
    always_comb
    begin
        for (int s = 0; s < IDS_PER_ENTRY; s++)
        begin
            slot_hit[s] = 1'b0;
            for (int q = 0; q < IDS_PER_ENTRY; q++)
            begin
                if (entry_row[s*W +: W] == query_row[q*W +: W])
                begin
                    slot_hit[s] = 1'b1;
                end
            end
        end
    end

    assign hit = &slot_hit;

endmodule

### rtl/unordered_id_set_table_search_unit.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// input    | in_valid / in_stall  | operation, entry_index, id_a .. id_d
// output   | out_valid / out_stall| found, match_index, probes
// config   | cfg_wr_en            | cfg_wr_data (entry_count)
//
// A load's result is registered at once. A search walks the entries from the
// scan start up to entry_count clipped to the table depth and ends on the first
// match or at the limit: the single table read port delivers one entry a cycle
// to the shared entry comparator.
// One item is in flight at a time; a finished result waits in the output
// register, and a stalled output holds the block before the next transfer.
// Reset clears the control state, entry count and scan start only; the table
// holds no valid bits and needs no clearing pass, so entries must be loaded before use.
module unordered_id_set_table_search_unit #(
    parameter int TABLE_DEPTH   = uidss_pkg::DEF_TABLE_DEPTH,
    parameter int IDS_PER_ENTRY = uidss_pkg::DEF_IDS_PER_ENTRY
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_wr_en,
    input  logic [uidss_pkg::CNT_W-1:0]         cfg_wr_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [uidss_pkg::IDX_W-1:0]         entry_index,
    input  logic signed [uidss_pkg::ID_W-1:0]   id_a,
    input  logic signed [uidss_pkg::ID_W-1:0]   id_b,
    input  logic signed [uidss_pkg::ID_W-1:0]   id_c,
    input  logic signed [uidss_pkg::ID_W-1:0]   id_d,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                found,
    output logic [uidss_pkg::IDX_W-1:0]         match_index,
    output logic [uidss_pkg::CNT_W-1:0]         probes
);

    localparam int W     = uidss_pkg::ID_W;
    localparam int CW    = uidss_pkg::CNT_W;
    localparam int IW    = uidss_pkg::IDX_W;
    localparam int ROW_W = IDS_PER_ENTRY * W;
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   entry_count_reg;
    logic [CW-1:0]   scan_start_reg, scan_start_next;
    logic [CW-1:0]   limit_reg, limit_next;
    logic [CW-1:0]   addr_reg, addr_next;
    logic [CW-1:0]   probe_cnt_reg, probe_cnt_next;
    logic            rd_pend_reg, rd_pend_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic [ROW_W-1:0] query_reg, query_next;
    logic [ROW_W-1:0] rd_data_reg;

    logic            res_found_reg, res_found_next;
    logic [IW-1:0]   res_idx_reg, res_idx_next;
    logic [CW-1:0]   res_probes_reg, res_probes_next;

    logic            out_valid_reg, out_valid_next;
    logic            found_reg, found_next;
    logic [IW-1:0]   match_index_reg, match_index_next;
    logic [CW-1:0]   probes_reg, probes_next;

    logic [W-1:0]    in_ids [uidss_pkg::QUERY_FIELDS];
    logic [ROW_W-1:0] in_row;
    logic            out_free;
    logic            in_xfer;
    logic            mem_we;
    logic            mem_re;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic            entry_hit;

    logic [ROW_W-1:0] table_mem [TABLE_DEPTH];

    assign in_ids[0] = id_a;
    assign in_ids[1] = id_b;
    assign in_ids[2] = id_c;
    assign in_ids[3] = id_d;

    for (genvar k = 0; k < IDS_PER_ENTRY; k++)
    begin : g_row
        if (k < uidss_pkg::QUERY_FIELDS)
        begin : g_field
            assign in_row[k*W +: W] = in_ids[k];
        end
        else
        begin : g_pad
            assign in_row[k*W +: W] = uidss_pkg::PAD_ID;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign in_xfer  = in_valid && !in_stall;

    assign mem_we  = in_xfer && (operation == uidss_pkg::OP_LOAD)
                     && (32'(entry_index) < TABLE_DEPTH);
    assign wr_addr = AW'(entry_index);
    assign mem_re  = (state_reg == ST_SCAN) && (addr_reg < limit_reg);
    assign rd_addr = AW'(addr_reg);

    uidss_match #(
        .IDS_PER_ENTRY (IDS_PER_ENTRY)
    ) u_match (
        .entry_row (rd_data_reg),
        .query_row (query_reg),
        .hit       (entry_hit)
    );

    always_comb
    begin
        state_next       = state_reg;
        scan_start_next  = scan_start_reg;
        limit_next       = limit_reg;
        addr_next        = addr_reg;
        probe_cnt_next   = probe_cnt_reg;
        rd_pend_next     = 1'b0;
        rd_idx_next      = rd_idx_reg;
        query_next       = query_reg;
        res_found_next   = res_found_reg;
        res_idx_next     = res_idx_reg;
        res_probes_next  = res_probes_reg;
        out_valid_next   = out_valid_reg && out_stall;
        found_next       = found_reg;
        match_index_next = match_index_reg;
        probes_next      = probes_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (operation == uidss_pkg::OP_LOAD)
                    begin
                        out_valid_next   = 1'b1;
                        found_next       = 1'b0;
                        match_index_next = '0;
                        probes_next      = '0;
                    end
                    else
                    begin
                        query_next     = in_row;
                        addr_next      = scan_start_reg;
                        probe_cnt_next = '0;
                        if (32'(entry_count_reg) > TABLE_DEPTH)
                        begin
                            limit_next = CW'(TABLE_DEPTH);
                        end
                        else
                        begin
                            limit_next = entry_count_reg;
                        end
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // The read of the next entry overlaps the compare of the last.
                if (mem_re)
                begin
                    rd_pend_next = 1'b1;
                    rd_idx_next  = addr_reg;
                    addr_next    = CW'(addr_reg + 1'b1);
                end
                if (rd_pend_reg && entry_hit)
                begin
                    rd_pend_next    = 1'b0;
                    res_found_next  = 1'b1;
                    res_idx_next    = rd_idx_reg[IW-1:0];
                    res_probes_next = CW'(probe_cnt_reg + 1'b1);
                    if (rd_idx_reg == scan_start_reg)
                    begin
                        scan_start_next = CW'(scan_start_reg + 1'b1);
                    end
                    state_next = ST_DONE;
                end
                else if (rd_pend_reg)
                begin
                    probe_cnt_next = CW'(probe_cnt_reg + 1'b1);
                end
                else if (!mem_re)
                begin
                    res_found_next  = 1'b0;
                    res_idx_next    = '0;
                    res_probes_next = probe_cnt_reg;
                    state_next      = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    found_next       = res_found_reg;
                    match_index_next = res_idx_reg;
                    probes_next      = res_probes_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            scan_start_reg  <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_start_reg <= scan_start_next;
            rd_pend_reg    <= rd_pend_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                entry_count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        limit_reg       <= limit_next;
        addr_reg        <= addr_next;
        probe_cnt_reg   <= probe_cnt_next;
        rd_idx_reg      <= rd_idx_next;
        query_reg       <= query_next;
        res_found_reg   <= res_found_next;
        res_idx_reg     <= res_idx_next;
        res_probes_reg  <= res_probes_next;
        found_reg       <= found_next;
        match_index_reg <= match_index_next;
        probes_reg      <= probes_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[wr_addr] <= in_row;
        end
        if (mem_re)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign match_index = match_index_reg;
    assign probes      = probes_reg;

    // An entry under compare always lies inside the current walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (rd_idx_reg < limit_reg) && (rd_idx_reg >= scan_start_reg))
    else $error("entry under compare lies outside the walk");

    // A reported match has examined at least the matching entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (probes_reg != '0))
    else $error("match reported with no probes");

    // A search always passes through the result stage before going idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (state_reg != ST_IDLE))
    else $error("search left the scan without a result");

endmodule

### verif/tb_unordered_id_set_table_search_unit.sv
module tb_unordered_id_set_table_search_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W          = uidss_pkg::ID_W;
    localparam int IDX_W         = uidss_pkg::IDX_W;
    localparam int CNT_W         = uidss_pkg::CNT_W;
    localparam int QUERY_FIELDS  = uidss_pkg::QUERY_FIELDS;
    localparam logic [ID_W-1:0] PAD_ID = uidss_pkg::PAD_ID;
    localparam logic OP_LOAD     = uidss_pkg::OP_LOAD;
    localparam logic OP_SEARCH   = uidss_pkg::OP_SEARCH;

    localparam int TABLE_DEPTH   = uidss_pkg::DEF_TABLE_DEPTH;
    localparam int IDS_PER_ENTRY = uidss_pkg::DEF_IDS_PER_ENTRY;
    localparam int MAX_REPORTS   = 10;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_ITEMS  = 119;
    localparam int RANDOM_PHASES = 7;

    typedef logic [ID_W-1:0] id_t;
    typedef logic [QUERY_FIELDS-1:0][ID_W-1:0] id_row_t;

    typedef struct packed
    {
        logic             op;
        logic [IDX_W-1:0] index;
        id_row_t          ids;
    } id_item_t;

    typedef struct packed
    {
        logic             found;
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] probes;
    } search_result_t;

    class table_search_board;
        id_row_t          tbl [TABLE_DEPTH];
        bit               loaded [TABLE_DEPTH];
        logic [CNT_W-1:0] scan_start;
        logic [CNT_W-1:0] entry_count;
        search_result_t   awaited [$];
        int               failures;
        int               loads;
        int               searches;
        int               hits;
        int               empty_walks;
        int               count_writes;
        int               longest_walk;

        function new();
            scan_start   = '0;
            entry_count  = '0;
            failures     = 0;
            loads        = 0;
            searches     = 0;
            hits         = 0;
            empty_walks  = 0;
            count_writes = 0;
            longest_walk = 0;
            foreach (loaded[i])
            begin
                loaded[i] = 1'b0;
            end
        endfunction

        function void set_entry_count(logic [CNT_W-1:0] value);
            entry_count = value;
            count_writes++;
        endfunction

        // Counts beyond the table depth are clipped to it.
        function int walk_limit();
            return (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        endfunction

        // Every stored id must appear somewhere in the query; order is irrelevant.
        function bit entry_hit(int e, id_row_t q);
            bit seen;
            for (int s = 0; s < IDS_PER_ENTRY; s++)
            begin
                seen = 1'b0;
                for (int k = 0; k < QUERY_FIELDS; k++)
                begin
                    if (tbl[e][s] == q[k])
                        seen = 1'b1;
                end
                if (!seen)
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // Returns the first never-loaded entry that a search with this query would
        // read, or -1 when the whole walk stays on loaded entries.
        function int first_unloaded(id_row_t q);
            for (int e = int'(scan_start); e < walk_limit(); e++)
            begin
                if (!loaded[e])
                    return e;
                if (entry_hit(e, q))
                    return -1;
            end
            return -1;
        endfunction

        function void note_input(id_item_t it);
            search_result_t r;
            int             lim;
            int             start;
            r = '0;
            if (it.op == OP_LOAD)
            begin
                tbl[it.index]    = it.ids;
                loaded[it.index] = 1'b1;
                loads++;
            end
            else
            begin
                searches++;
                lim   = walk_limit();
                start = int'(scan_start);
                if (start >= lim)
                    empty_walks++;
                for (int e = start; e < lim; e++)
                begin
                    r.probes++;
                    if (entry_hit(e, it.ids))
                    begin
                        r.found = 1'b1;
                        r.index = IDX_W'(e);
                        hits++;
                        if (e == start)
                            scan_start++;
                        break;
                    end
                end
                if (int'(r.probes) > longest_walk)
                    longest_walk = int'(r.probes);
            end
            awaited.push_back(r);
        endfunction

        function void check_result(search_result_t got);
            search_result_t want;
            if (awaited.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: result with nothing outstanding: %s%0d %s%0d %s%0d",
                             $time, "found=", got.found, "index=", got.index,
                             "probes=", got.probes);
                return;
            end
            want = awaited.pop_front();
            if (got.found !== want.found || got.index !== want.index ||
                got.probes !== want.probes)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: result differs: expected found=%0d index=%0d %s%0d, %s",
                             $time, want.found, want.index, "probes=", want.probes,
                             $sformatf("got found=%0d index=%0d probes=%0d",
                                       got.found, got.index, got.probes));
            end
        endfunction
    endclass

    logic                    clk         = 1'b0;
    logic                    rst_n       = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [CNT_W-1:0]        cfg_wr_data = '0;
    logic                    in_valid    = 1'b0;
    logic                    in_stall;
    logic                    operation   = OP_LOAD;
    logic [IDX_W-1:0]        entry_index = '0;
    logic signed [ID_W-1:0]  id_a        = '0;
    logic signed [ID_W-1:0]  id_b        = '0;
    logic signed [ID_W-1:0]  id_c        = '0;
    logic signed [ID_W-1:0]  id_d        = '0;
    logic                    out_valid;
    logic                    out_stall   = 1'b0;
    logic                    found;
    logic [IDX_W-1:0]        match_index;
    logic [CNT_W-1:0]        probes;

    table_search_board board;
    int unsigned       cycles      = 0;
    int                burst_left  = 0;
    bit                holding     = 1'b0;
    int                stall_mode  = 0;
    int                stall_left  = 0;
    int                stall_tick  = 0;

    unordered_id_set_table_search_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .entry_index (entry_index),
        .id_a        (id_a),
        .id_b        (id_b),
        .id_c        (id_c),
        .id_d        (id_d),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .match_index (match_index),
        .probes      (probes)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles with %0d results outstanding",
                     cycles, board.awaited.size());
            $display("unordered_id_set_table_search_unit: mismatch");
            $finish;
        end
    end

    // The receiver switches between free flow, light and heavy random stalls and
    // a fixed three-in-five pattern.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ((stall_tick % 5) < 3);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(search_result_t'{found, match_index, probes});
    end

    function automatic id_item_t make_item(logic op, int idx, id_t a, id_t b, id_t c, id_t d);
        id_item_t it;
        it.op    = op;
        it.index = IDX_W'(idx);
        it.ids   = {d, c, b, a};
        return it;
    endfunction

    // Ids are mostly drawn from a small pool so that duplicates and partial overlaps
    // between entries and queries are common.
    function automatic id_t random_id();
        case ($urandom_range(0, 5))
            0:       return PAD_ID;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3, 4:    return id_t'($urandom_range(0, 7));
            default: return $urandom() & 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic id_row_t shuffled(id_row_t row);
        id_t t;
        int  j;
        for (int i = QUERY_FIELDS - 1; i > 0; i--)
        begin
            j      = $urandom_range(0, i);
            t      = row[i];
            row[i] = row[j];
            row[j] = t;
        end
        return row;
    endfunction

    // Mostly loads near the scan start and searches for permutations of loaded
    // entries. A search that would read a never-loaded entry becomes a load of it.
    function automatic id_item_t random_item();
        id_item_t it;
        int       base;
        int       e;
        base  = int'(board.scan_start);
        it.op = ($urandom_range(0, 1) == 0) ? OP_LOAD : OP_SEARCH;
        if ($urandom_range(0, 6) == 0 || base + 31 >= TABLE_DEPTH)
            it.index = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
        else
            it.index = IDX_W'(base + $urandom_range(0, 31));
        for (int k = 0; k < QUERY_FIELDS; k++)
        begin
            it.ids[k] = random_id();
        end
        if (it.op == OP_SEARCH)
        begin
            e = base + $urandom_range(0, 31);
            if (e < TABLE_DEPTH && board.loaded[e] && $urandom_range(0, 9) < 8)
            begin
                it.ids = shuffled(board.tbl[e]);
                if ($urandom_range(0, 3) == 0)
                    it.ids[$urandom_range(0, QUERY_FIELDS - 1)] = random_id();
            end
            e = board.first_unloaded(it.ids);
            if (e >= 0)
            begin
                it.op    = OP_LOAD;
                it.index = IDX_W'(e);
            end
        end
        return it;
    endfunction

    task automatic push(id_item_t it);
        in_valid    <= 1'b1;
        operation   <= it.op;
        entry_index <= it.index;
        id_a        <= it.ids[0];
        id_b        <= it.ids[1];
        id_c        <= it.ids[2];
        id_d        <= it.ids[3];
        holding = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        board.note_input(it);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
            in_valid <= 1'b0;
            holding = 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Holds the sender off until every outstanding result has been transferred.
    task automatic drain();
        if (holding)
        begin
            in_valid <= 1'b0;
            holding = 1'b0;
        end
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_entry_count(logic [CNT_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.set_entry_count(value);
    endtask

    initial
    begin
        int             pushed;
        int             per_phase;
        logic [CNT_W-1:0] count;
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table walk, then a small table exercising each
        // kind of hit, a full miss and the scan start moving on.
        write_entry_count('0);
        push(make_item(OP_SEARCH, TABLE_DEPTH - 1, PAD_ID, PAD_ID, PAD_ID, PAD_ID));
        push(make_item(OP_LOAD, 0, PAD_ID, PAD_ID, PAD_ID, PAD_ID));
        push(make_item(OP_LOAD, 1, 32'h7FFF_FFFF, 0, 1, PAD_ID));
        push(make_item(OP_LOAD, 2, 5, 5, 5, 5));
        push(make_item(OP_LOAD, 3, 0, 0, 0, 0));
        push(make_item(OP_LOAD, 4, 10, 20, 30, 40));
        push(make_item(OP_LOAD, 5, 7, 8, PAD_ID, PAD_ID));
        push(make_item(OP_LOAD, 6, 100, 200, 300, 400));
        push(make_item(OP_LOAD, 7, 32'h1234_5678, 32'h7FFF_FFFF, 3, 9));
        push(make_item(OP_LOAD, TABLE_DEPTH - 1, 1, 1, 1, 1));
        push(make_item(OP_LOAD, TABLE_DEPTH / 2, 2, 2, 2, 2));
        drain();
        write_entry_count(8);
        push(make_item(OP_SEARCH, 0, PAD_ID, PAD_ID, PAD_ID, PAD_ID));
        push(make_item(OP_SEARCH, TABLE_DEPTH - 1, PAD_ID, 1, 0, 32'h7FFF_FFFF));
        push(make_item(OP_SEARCH, 0, 9, 5, 11, 12));
        push(make_item(OP_SEARCH, 0, 10, 20, 30, 99));
        push(make_item(OP_SEARCH, 0, 8, 7, PAD_ID, PAD_ID));
        push(make_item(OP_SEARCH, 0, 0, 1, 2, 3));
        drain();
        // The scan start now lies beyond the limit, so the walk is empty.
        write_entry_count(3);
        push(make_item(OP_SEARCH, 0, 0, 0, 0, 0));
        drain();
        write_entry_count('1);
        push(make_item(OP_SEARCH, 0, 40, 30, 20, 10));
        push(make_item(OP_SEARCH, 0, 400, 300, 200, 100));
        drain();

        pushed    = 0;
        per_phase = RANDOM_ITEMS / RANDOM_PHASES;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                1:       count = '0;
                2:       count = CNT_W'(TABLE_DEPTH);
                3:       count = '1;
                default: count = CNT_W'(int'(board.scan_start) + $urandom_range(0, 24));
            endcase
            write_entry_count(count);
            for (int i = 0; i < per_phase; i++)
            begin
                push(random_item());
                pushed++;
                if ($urandom_range(0, 24) == 0)
                    drain();
            end
            drain();
        end
        repeat (20) @(posedge clk);

        $display("covered %0d loads and %0d searches (%0d hits, %0d empty walks)",
                 board.loads, board.searches, board.hits, board.empty_walks);
        $display("%0d entry_count writes, longest walk %0d probes, %s %0d, %0d random items",
                 board.count_writes, board.longest_walk, "scan start ended at",
                 board.scan_start, pushed);
        if (board.failures == 0 && board.awaited.size() == 0)
            $display("unordered_id_set_table_search_unit: match");
        else
            $display("unordered_id_set_table_search_unit: mismatch");
        $finish;
    end
endmodule
